// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tri_stf_pkg.sv -----
// Types, widths and helpers shared by the triangle stiffness pipeline.
`timescale 1ns / 1ps
`default_nettype none
package tri_stf_pkg;

  localparam int COORD_W = 32;              // corner coordinate
  localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;      // difference product
  localparam int S_W     = PROD_W + 1;      // twice the signed area
  localparam int DEN_W   = S_W + 1;         // divisor 2*S
  localparam int D_W     = 48;              // material entry
  localparam int LO_W    = 16;              // low split of a material entry
  localparam int DB_W    = 83;              // one entry of D*Bu
  localparam int N_W     = 120;             // one entry of Bu^T*D*Bu
  localparam int Q_W     = 64;              // result word
  localparam int NUM_D   = 6;
  localparam int CFG_AW  = 3;
  localparam int IN_W    = 6 * COORD_W;
  localparam int OUT_W   = 72;
  localparam int USER_W  = 3;

  localparam logic [CFG_AW-1:0] REG_D_XX = 3'd0;
  localparam logic [CFG_AW-1:0] REG_D_XY = 3'd1;
  localparam logic [CFG_AW-1:0] REG_D_XS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_D_YY = 3'd3;
  localparam logic [CFG_AW-1:0] REG_D_YS = 3'd4;
  localparam logic [CFG_AW-1:0] REG_D_SS = 3'd5;

  localparam logic [2:0] IDX_LAST = 3'd5;

  localparam logic [Q_W-1:0] VAL_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] VAL_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2
  } status_t;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // rows 0..2 of one column of the unscaled strain-displacement matrix
  typedef logic [2:0][DIFF_W-1:0] col_t;

  typedef struct packed {
    diff_t a;  // y2-y3
    diff_t b;  // y3-y1
    diff_t c;  // y1-y2
    diff_t d;  // x3-x2
    diff_t e;  // x1-x3
    diff_t f;  // x2-x1
  } diffs_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    status_t    status;
    logic       last;
  } tag_t;

  function automatic diff_t coord_diff(input logic [COORD_W-1:0] p,
                                       input logic [COORD_W-1:0] m);
    return $signed({p[COORD_W-1], p}) - $signed({m[COORD_W-1], m});
  endfunction

  function automatic col_t bu_col(input logic [2:0] idx, input diffs_t df);
    col_t c;
    c = '0;
    case (idx)
      3'd0: begin c[0] = df.a; c[2] = df.d; end
      3'd1: begin c[1] = df.d; c[2] = df.a; end
      3'd2: begin c[0] = df.b; c[2] = df.e; end
      3'd3: begin c[1] = df.e; c[2] = df.b; end
      3'd4: begin c[0] = df.c; c[2] = df.f; end
      3'd5: begin c[1] = df.f; c[2] = df.c; end
      default: begin c = '0; end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tri_stf_front.sv -----
// Input stages, area computation and the 36-entry issue sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tri_stf_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           ce,
  input  wire logic                           in_tvalid,
  input  wire logic [tri_stf_pkg::IN_W-1:0]   in_tdata,
  output logic                                in_tready,
  output logic                                iss_valid,
  output tri_stf_pkg::tag_t                   iss_tag,
  output tri_stf_pkg::col_t                   iss_col_i,
  output tri_stf_pkg::col_t                   iss_col_j,
  output logic [tri_stf_pkg::S_W-1:0]         iss_s
);

  localparam int CW = tri_stf_pkg::COORD_W;

  logic                                   t0_v_r;
  tri_stf_pkg::diffs_t                    t0_df_r;
  logic                                   t1_v_r;
  tri_stf_pkg::diffs_t                    t1_df_r;
  logic signed [tri_stf_pkg::PROD_W-1:0]  t1_p1_r;
  logic signed [tri_stf_pkg::PROD_W-1:0]  t1_p2_r;

  logic                                   seq_act_r;
  tri_stf_pkg::diffs_t                    seq_df_r;
  logic signed [tri_stf_pkg::S_W-1:0]     seq_s_r;
  tri_stf_pkg::status_t                   seq_status_r;
  logic [2:0]                             row_r;
  logic [2:0]                             col_r;

  logic                                   iss_v_r;
  tri_stf_pkg::tag_t                      iss_tag_r;
  tri_stf_pkg::col_t                      iss_col_i_r;
  tri_stf_pkg::col_t                      iss_col_j_r;
  logic [tri_stf_pkg::S_W-1:0]            iss_s_r;

  logic                                   seq_lastnow;
  logic                                   load;
  logic                                   t1_free;
  logic                                   t0_move;
  logic                                   in_acc;
  logic signed [tri_stf_pkg::S_W-1:0]     s_nxt;
  tri_stf_pkg::status_t                   status_nxt;

  assign seq_lastnow = (seq_status_r != tri_stf_pkg::ST_OK) ||
                       (row_r == tri_stf_pkg::IDX_LAST && col_r == tri_stf_pkg::IDX_LAST);
  assign load      = ce && t1_v_r && (!seq_act_r || seq_lastnow);
  assign t1_free   = !t1_v_r || load;
  assign t0_move   = ce && t0_v_r && t1_free;
  assign in_tready = ce && (!t0_v_r || t0_move);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s_nxt = tri_stf_pkg::S_W'(t1_p1_r) - tri_stf_pkg::S_W'(t1_p2_r);
    if (s_nxt == '0) begin
      status_nxt = tri_stf_pkg::ST_ZERO;
    end else if (s_nxt[tri_stf_pkg::S_W-1]) begin
      status_nxt = tri_stf_pkg::ST_NEG;
    end else begin
      status_nxt = tri_stf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r    <= 1'b0;
      t1_v_r    <= 1'b0;
      seq_act_r <= 1'b0;
      iss_v_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        t0_v_r <= 1'b1;
      end else if (t0_move) begin
        t0_v_r <= 1'b0;
      end
      if (t0_move) begin
        t1_v_r <= 1'b1;
      end else if (load) begin
        t1_v_r <= 1'b0;
      end
      if (load) begin
        seq_act_r <= 1'b1;
      end else if (ce && seq_act_r && seq_lastnow) begin
        seq_act_r <= 1'b0;
      end
      if (ce) begin
        iss_v_r <= seq_act_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t0_df_r.a <= tri_stf_pkg::coord_diff(in_tdata[4*CW-1 -: CW], in_tdata[6*CW-1 -: CW]);
      t0_df_r.b <= tri_stf_pkg::coord_diff(in_tdata[6*CW-1 -: CW], in_tdata[2*CW-1 -: CW]);
      t0_df_r.c <= tri_stf_pkg::coord_diff(in_tdata[2*CW-1 -: CW], in_tdata[4*CW-1 -: CW]);
      t0_df_r.d <= tri_stf_pkg::coord_diff(in_tdata[5*CW-1 -: CW], in_tdata[3*CW-1 -: CW]);
      t0_df_r.e <= tri_stf_pkg::coord_diff(in_tdata[CW-1:0], in_tdata[5*CW-1 -: CW]);
      t0_df_r.f <= tri_stf_pkg::coord_diff(in_tdata[3*CW-1 -: CW], in_tdata[CW-1:0]);
    end
    if (t0_move) begin
      t1_df_r <= t0_df_r;
      t1_p1_r <= t0_df_r.f * t0_df_r.b;
      t1_p2_r <= t0_df_r.e * t0_df_r.c;
    end
    if (load) begin
      seq_df_r     <= t1_df_r;
      seq_s_r      <= s_nxt;
      seq_status_r <= status_nxt;
      row_r        <= '0;
      col_r        <= '0;
    end else if (ce && seq_act_r && !seq_lastnow) begin
      // advance row-major over the 6x6 matrix
      if (col_r == tri_stf_pkg::IDX_LAST) begin
        col_r <= '0;
        row_r <= row_r + 3'd1;
      end else begin
        col_r <= col_r + 3'd1;
      end
    end
    if (ce) begin
      iss_tag_r.row    <= (seq_status_r == tri_stf_pkg::ST_OK) ? row_r : 3'd0;
      iss_tag_r.col    <= (seq_status_r == tri_stf_pkg::ST_OK) ? col_r : 3'd0;
      iss_tag_r.status <= seq_status_r;
      iss_tag_r.last   <= seq_lastnow;
      iss_col_i_r      <= tri_stf_pkg::bu_col(row_r, seq_df_r);
      iss_col_j_r      <= tri_stf_pkg::bu_col(col_r, seq_df_r);
      iss_s_r          <= seq_s_r;
    end
  end

  assign iss_valid = iss_v_r;
  assign iss_tag   = iss_tag_r;
  assign iss_col_i = iss_col_i_r;
  assign iss_col_j = iss_col_j_r;
  assign iss_s     = iss_s_r;

endmodule
`default_nettype wire

// ----- rtl/tri_stf_mac.sv -----
// Multiply-accumulate pipeline forming Bu^T*D*Bu, the rounding numerator and divisor.
`timescale 1ns / 1ps
`default_nettype none
module tri_stf_mac (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          ce,
  input  wire logic [tri_stf_pkg::NUM_D-1:0][tri_stf_pkg::D_W-1:0] d_cfg,
  input  wire logic                                          iss_valid,
  input  wire tri_stf_pkg::tag_t                             iss_tag,
  input  wire tri_stf_pkg::col_t                             iss_col_i,
  input  wire tri_stf_pkg::col_t                             iss_col_j,
  input  wire logic [tri_stf_pkg::S_W-1:0]                   iss_s,
  output logic                                               mac_valid,
  output tri_stf_pkg::tag_t                                  mac_tag,
  output logic                                               mac_neg,
  output logic [tri_stf_pkg::N_W-1:0]                        mac_num,
  output logic [tri_stf_pkg::DEN_W-1:0]                      mac_den
);

  localparam int D_W  = tri_stf_pkg::D_W;
  localparam int LO_W = tri_stf_pkg::LO_W;
  localparam int DB_W = tri_stf_pkg::DB_W;
  localparam int N_W  = tri_stf_pkg::N_W;
  localparam int HP_W = D_W - LO_W + tri_stf_pkg::DIFF_W;
  localparam int LP_W = LO_W + 1 + tri_stf_pkg::DIFF_W;
  localparam int P_W  = tri_stf_pkg::PROD_W;

  logic [D_W-1:0] dm [3][3];

  // stage 1: split partial products of D*Bu column j
  logic                          m1_v_r;
  tri_stf_pkg::tag_t             m1_tag_r;
  tri_stf_pkg::col_t             m1_coli_r;
  logic [tri_stf_pkg::S_W-1:0]   m1_s_r;
  logic signed [HP_W-1:0]        m1_hi_r [3][3];
  logic signed [LP_W-1:0]        m1_lo_r [3][3];
  // stage 2: D*Bu column j
  logic                          m2_v_r;
  tri_stf_pkg::tag_t             m2_tag_r;
  tri_stf_pkg::col_t             m2_coli_r;
  logic [tri_stf_pkg::S_W-1:0]   m2_s_r;
  logic signed [DB_W-1:0]        m2_db_r [3];
  logic signed [DB_W-1:0]        db_nxt [3];
  // stage 3: chunked products with Bu column i
  logic                          m3_v_r;
  tri_stf_pkg::tag_t             m3_tag_r;
  logic [tri_stf_pkg::S_W-1:0]   m3_s_r;
  logic signed [P_W-1:0]         m3_p_r [3][3];
  // stage 4: per-row partial sums
  logic                          m4_v_r;
  tri_stf_pkg::tag_t             m4_tag_r;
  logic [tri_stf_pkg::S_W-1:0]   m4_s_r;
  logic signed [N_W-1:0]         m4_n_r [3];
  // stage 5: full sum
  logic                          m5_v_r;
  tri_stf_pkg::tag_t             m5_tag_r;
  logic [tri_stf_pkg::S_W-1:0]   m5_s_r;
  logic signed [N_W-1:0]         m5_n_r;
  // stage 6: magnitude plus half the divisor
  logic                          m6_v_r;
  tri_stf_pkg::tag_t             m6_tag_r;
  logic                          m6_neg_r;
  logic [N_W-1:0]                m6_num_r;
  logic [tri_stf_pkg::DEN_W-1:0] m6_den_r;
  logic signed [N_W-1:0]         mag;

  always_comb begin
    dm[0][0] = d_cfg[tri_stf_pkg::REG_D_XX];
    dm[0][1] = d_cfg[tri_stf_pkg::REG_D_XY];
    dm[0][2] = d_cfg[tri_stf_pkg::REG_D_XS];
    dm[1][0] = d_cfg[tri_stf_pkg::REG_D_XY];
    dm[1][1] = d_cfg[tri_stf_pkg::REG_D_YY];
    dm[1][2] = d_cfg[tri_stf_pkg::REG_D_YS];
    dm[2][0] = d_cfg[tri_stf_pkg::REG_D_XS];
    dm[2][1] = d_cfg[tri_stf_pkg::REG_D_YS];
    dm[2][2] = d_cfg[tri_stf_pkg::REG_D_SS];
  end

  always_comb begin
    logic signed [DB_W-1:0] acc;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int l = 0; l < 3; l++) begin
        acc = acc + (DB_W'(m1_hi_r[k][l]) <<< LO_W) + DB_W'(m1_lo_r[k][l]);
      end
      db_nxt[k] = acc;
    end
  end

  assign mag = m5_n_r[N_W-1] ? -m5_n_r : m5_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      m5_v_r <= 1'b0;
      m6_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= iss_valid;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
      m6_v_r <= m5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_tag_r  <= iss_tag;
      m1_coli_r <= iss_col_i;
      m1_s_r    <= iss_s;
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          m1_hi_r[k][l] <= $signed(dm[k][l][D_W-1:LO_W]) * $signed(iss_col_j[l]);
          m1_lo_r[k][l] <= $signed({1'b0, dm[k][l][LO_W-1:0]}) * $signed(iss_col_j[l]);
        end
      end

      m2_tag_r  <= m1_tag_r;
      m2_coli_r <= m1_coli_r;
      m2_s_r    <= m1_s_r;
      for (int k = 0; k < 3; k++) begin
        m2_db_r[k] <= db_nxt[k];
      end

      m3_tag_r <= m2_tag_r;
      m3_s_r   <= m2_s_r;
      for (int k = 0; k < 3; k++) begin
        m3_p_r[k][0] <= $signed({1'b0, m2_db_r[k][31:0]}) * $signed(m2_coli_r[k]);
        m3_p_r[k][1] <= $signed({1'b0, m2_db_r[k][63:32]}) * $signed(m2_coli_r[k]);
        m3_p_r[k][2] <= P_W'($signed(m2_db_r[k][DB_W-1:64]) * $signed(m2_coli_r[k]));
      end

      m4_tag_r <= m3_tag_r;
      m4_s_r   <= m3_s_r;
      for (int k = 0; k < 3; k++) begin
        m4_n_r[k] <= N_W'(m3_p_r[k][0]) + (N_W'(m3_p_r[k][1]) <<< 32) +
                     (N_W'(m3_p_r[k][2]) <<< 64);
      end

      m5_tag_r <= m4_tag_r;
      m5_s_r   <= m4_s_r;
      m5_n_r   <= m4_n_r[0] + m4_n_r[1] + m4_n_r[2];

      m6_tag_r <= m5_tag_r;
      m6_neg_r <= m5_n_r[N_W-1];
      m6_num_r <= N_W'(mag) + N_W'(m5_s_r);
      m6_den_r <= {m5_s_r, 1'b0};
    end
  end

  assign mac_valid = m6_v_r;
  assign mac_tag   = m6_tag_r;
  assign mac_neg   = m6_neg_r;
  assign mac_num   = m6_num_r;
  assign mac_den   = m6_den_r;

endmodule
`default_nettype wire

// ----- rtl/tri_stf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
`default_nettype none
module tri_stf_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            ce,
  input  wire logic                            mac_valid,
  input  wire tri_stf_pkg::tag_t               mac_tag,
  input  wire logic                            mac_neg,
  input  wire logic [tri_stf_pkg::N_W-1:0]     mac_num,
  input  wire logic [tri_stf_pkg::DEN_W-1:0]   mac_den,
  output logic                                 div_valid,
  output tri_stf_pkg::tag_t                    div_tag,
  output logic                                 div_neg,
  output logic                                 div_ovf,
  output logic [tri_stf_pkg::Q_W-1:0]          div_q
);

  localparam int Q_W   = tri_stf_pkg::Q_W;
  localparam int DEN_W = tri_stf_pkg::DEN_W;
  localparam int N_W   = tri_stf_pkg::N_W;

  logic                 v_r   [Q_W+1];
  tri_stf_pkg::tag_t    tag_r [Q_W+1];
  logic                 neg_r [Q_W+1];
  logic                 ovf_r [Q_W+1];
  logic [DEN_W-1:0]     den_r [Q_W+1];
  logic [DEN_W-1:0]     rem_r [Q_W+1];
  logic [Q_W-1:0]       lo_r  [Q_W+1];
  logic [Q_W-1:0]       q_r   [Q_W+1];

  // quotient of 2^64 or more means the entry clips whatever its sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= mac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag_r[0] <= mac_tag;
      neg_r[0] <= mac_neg;
      ovf_r[0] <= DEN_W'(mac_num[N_W-1:Q_W]) >= mac_den;
      den_r[0] <= mac_den;
      rem_r[0] <= DEN_W'(mac_num[N_W-1:Q_W]);
      lo_r[0]  <= mac_num[Q_W-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem_r[s-1], lo_r[s-1][Q_W-1]};
    assign ge    = trial >= {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (ce) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        tag_r[s] <= tag_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        den_r[s] <= den_r[s-1];
        rem_r[s] <= ge ? DEN_W'(trial - {1'b0, den_r[s-1]}) : trial[DEN_W-1:0];
        lo_r[s]  <= {lo_r[s-1][Q_W-2:0], 1'b0};
        q_r[s]   <= {q_r[s-1][Q_W-2:0], ge};
      end
    end
  end

  assign div_valid = v_r[Q_W];
  assign div_tag   = tag_r[Q_W];
  assign div_neg   = neg_r[Q_W];
  assign div_ovf   = ovf_r[Q_W];
  assign div_q     = q_r[Q_W];

endmodule
`default_nettype wire

// ----- rtl/triangle_element_stiffness_top.sv -----
// Top level of the constant-strain triangle stiffness pipeline.
// Throughput: one entry per cycle unless out_tready stalls; 36 entries per triangle.
// A zero or negative area triangle gives one flagged entry.
// Reset (rst_n low, synchronous) clears all valid bits and the material registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module triangle_element_stiffness_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tri_stf_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [tri_stf_pkg::D_W-1:0]      cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  wire logic [tri_stf_pkg::IN_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // row_index, col_index, entry_value, zero pad
  output logic [tri_stf_pkg::OUT_W-1:0]         out_tdata,
  // status, saturated
  output logic [tri_stf_pkg::USER_W-1:0]        out_tuser,
  output logic                                  out_tlast
);

  localparam int Q_W = tri_stf_pkg::Q_W;

  logic [tri_stf_pkg::NUM_D-1:0][tri_stf_pkg::D_W-1:0] d_r;

  logic                                 ce;
  logic                                 iss_valid;
  tri_stf_pkg::tag_t                    iss_tag;
  tri_stf_pkg::col_t                    iss_col_i;
  tri_stf_pkg::col_t                    iss_col_j;
  logic [tri_stf_pkg::S_W-1:0]          iss_s;
  logic                                 mac_valid;
  tri_stf_pkg::tag_t                    mac_tag;
  logic                                 mac_neg;
  logic [tri_stf_pkg::N_W-1:0]          mac_num;
  logic [tri_stf_pkg::DEN_W-1:0]        mac_den;
  logic                                 div_valid;
  tri_stf_pkg::tag_t                    div_tag;
  logic                                 div_neg;
  logic                                 div_ovf;
  logic [Q_W-1:0]                       div_q;

  logic                                 out_valid_r;
  tri_stf_pkg::tag_t                    out_tag_r;
  logic [Q_W-1:0]                       out_val_r;
  logic                                 out_sat_r;
  logic [Q_W-1:0]                       val_nxt;
  logic                                 sat_nxt;

  // the whole pipeline holds while a finished word waits
  assign ce = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (cfg_we && (cfg_addr <= tri_stf_pkg::REG_D_SS)) begin
      d_r[cfg_addr] <= cfg_wdata;
    end
  end

  tri_stf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tready (in_tready),
    .iss_valid (iss_valid),
    .iss_tag   (iss_tag),
    .iss_col_i (iss_col_i),
    .iss_col_j (iss_col_j),
    .iss_s     (iss_s)
  );

  tri_stf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .d_cfg     (d_r),
    .iss_valid (iss_valid),
    .iss_tag   (iss_tag),
    .iss_col_i (iss_col_i),
    .iss_col_j (iss_col_j),
    .iss_s     (iss_s),
    .mac_valid (mac_valid),
    .mac_tag   (mac_tag),
    .mac_neg   (mac_neg),
    .mac_num   (mac_num),
    .mac_den   (mac_den)
  );

  tri_stf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .mac_valid (mac_valid),
    .mac_tag   (mac_tag),
    .mac_neg   (mac_neg),
    .mac_num   (mac_num),
    .mac_den   (mac_den),
    .div_valid (div_valid),
    .div_tag   (div_tag),
    .div_neg   (div_neg),
    .div_ovf   (div_ovf),
    .div_q     (div_q)
  );

  always_comb begin
    if (div_tag.status != tri_stf_pkg::ST_OK) begin
      sat_nxt = 1'b0;
      val_nxt = '0;
    end else if (div_neg) begin
      // magnitude of exactly 2^63 still fits as the most negative value
      sat_nxt = div_ovf || (div_q[Q_W-1] && (|div_q[Q_W-2:0]));
      val_nxt = sat_nxt ? tri_stf_pkg::VAL_MIN : -div_q;
    end else begin
      sat_nxt = div_ovf || div_q[Q_W-1];
      val_nxt = sat_nxt ? tri_stf_pkg::VAL_MAX : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tag_r <= div_tag;
      out_val_r <= val_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_tag_r.col, out_tag_r.row};
  assign out_tuser  = {out_sat_r, out_tag_r.status};
  assign out_tlast  = out_tag_r.last;

  `ASSERT_IMPL(a_flag_single, out_valid_r && (out_tag_r.status != tri_stf_pkg::ST_OK), out_tag_r.last && (out_tag_r.row == 3'd0) && (out_tag_r.col == 3'd0) && !out_sat_r && (out_val_r == '0), "flagged triangle word must be a lone zero word")
  `ASSERT_IMPL(a_last_pos, out_valid_r && (out_tag_r.status == tri_stf_pkg::ST_OK), out_tag_r.last == ((out_tag_r.row == tri_stf_pkg::IDX_LAST) && (out_tag_r.col == tri_stf_pkg::IDX_LAST)), "last mark off the final matrix entry")
  `ASSERT_IMPL(a_sat_value, out_valid_r && out_sat_r, (out_val_r == tri_stf_pkg::VAL_MAX) || (out_val_r == tri_stf_pkg::VAL_MIN), "clipped entry not at a range limit")

endmodule
`default_nettype wire
